// File: rtl/fmng_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fmng_pkg;

	localparam int MAX_PINS    = 16;
	localparam int NODE_BITS   = 16;
	localparam int MAX_RESULTS = 16;

	// Width of a node id as the block keeps it: the input field carries 16 bits.
	localparam int NODE_W = (NODE_BITS < 16) ? NODE_BITS : 16;
	localparam int IDX_W  = $clog2(MAX_PINS);
	localparam int CNT_W  = $clog2(MAX_PINS + 1);
	localparam int RES_W  = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_MOVE  = 2'd2;

	localparam logic [1:0] CHG_NONE   = 2'd0;
	localparam logic [1:0] CHG_INC    = 2'd1;
	localparam logic [1:0] CHG_REDUCE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOT_PIN = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] node_id;
		logic        side;
	} req_t;

	typedef struct packed {
		logic [15:0] gain_node;
		logic [1:0]  gain_change;
		logic        net_critical;
		logic [1:0]  status;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic              side;
		logic [NODE_W-1:0] node;
	} pin_t;

endpackage

`default_nettype wire

// File: rtl/fm_net_gain_update.sv
`timescale 1ns / 1ps
`default_nettype none

// Pin table of one net for a Fiduccia-Mattheyses partitioning pass.
// The req channel carries one transaction per operation: clear the net for a
// new pass, add a pin (node id and side), or move the node of an unlocked pin.
// The rsp channel returns one or more transactions per operation; the final
// one has last set. A move returns one transaction per gain update of another
// pin (increase or reduce), or a single transaction with no change.
// Node id and side of each pin live in a synchronous memory with a registered
// read; lock bits, pin count and the net flags are flip-flops.
// A clear or an unused code goes straight to the final result. An add reads
// each pin in the table once from memory to search for the node and count
// sides. A move does the same search and then up to two emission scans over
// the table, one memory read per pin and scan through the single read port.
// A new request is taken only when the previous one has handed its last
// result to the output register, so a request can enter while that result
// still waits on a stalled receiver. An emission scan holds on a pin with a
// result to pass on while rsp_stall keeps the output register full.
// Reset empties the table, clears all locks and the frozen flag and sets the
// critical flag; no clearing pass is needed.

module fm_net_gain_update (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire fmng_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output fmng_pkg::rsp_t     rsp
);
	import fmng_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FIND = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]          state_q;
	logic [1:0]          op_q;
	logic [NODE_W-1:0]   node_q;
	logic                side_q;

	logic [CNT_W-1:0]    count_q;
	logic [MAX_PINS-1:0] pin_locked_q;
	logic                crit_q;
	logic                frozen_q;

	// Pin memory: one entry per pin, with the read data registered from the address.
	pin_t                pin_mem [MAX_PINS];
	pin_t                rd_s1;
	logic [IDX_W-1:0]    raddr;
	logic [IDX_W-1:0]    idx_q;

	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	pin_t                wr_data;

	// Search results and side counts gathered during the search scan.
	logic                found_q;
	logic [IDX_W-1:0]    m_q;
	logic                msd_q;
	logic [CNT_W-1:0]    u0_q, u1_q, l0_q, l1_q;

	logic                g2_q, g1inc_q, g2inc_q, grp_q;

	// The newest result is held back until the next one shows whether it is last.
	rsp_t                pend_q;
	logic                pend_soft_q;
	logic [RES_W-1:0]    n_q;

	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                slot_free;
	logic                accept;
	logic                scanning;
	logic                lk;
	logic                last_entry;
	logic                match;
	logic                inc_sel;
	logic                qual;
	logic                emit_real;
	logic                consume;
	logic                rsp_load;

	logic [CNT_W-1:0]    c0, c1;
	logic                add_ok;
	logic                crit_add;
	logic [CNT_W-1:0]    fu, fl, tu, tl;
	logic                crit_mv;
	logic                frz_mv;
	logic                g1, g2;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		scanning   = (state_q == S_FIND) || (state_q == S_EMIT);
		lk         = pin_locked_q[idx_q];
		last_entry = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
		match      = (rd_s1.node == node_q) && ((op_q != OP_MOVE) || !lk);
		inc_sel    = grp_q ? g2inc_q : g1inc_q;
		if (inc_sel) begin
			qual = !lk && (rd_s1.side == msd_q) && (idx_q != m_q);
		end else begin
			qual = !lk && (rd_s1.side != msd_q);
		end
		emit_real = (state_q == S_EMIT) && qual && (n_q != RES_W'(MAX_RESULTS));
		consume   = !emit_real || pend_soft_q || slot_free;
		rsp_load  = ((state_q == S_EMIT) && emit_real && consume && !pend_soft_q) ||
			((state_q == S_FIN) && slot_free);
		if (scanning && !consume) begin
			raddr = idx_q;
		end else if (scanning && !last_entry) begin
			raddr = idx_q + IDX_W'(1);
		end else begin
			raddr = '0;
		end
	end

	// Add: side totals after the pin is appended or its side rewritten.
	always_comb begin
		c0     = u0_q + l0_q;
		c1     = u1_q + l1_q;
		add_ok = found_q || (count_q < CNT_W'(MAX_PINS));
		if (found_q) begin
			if (!msd_q && side_q) begin
				c0 = c0 - CNT_W'(1);
				c1 = c1 + CNT_W'(1);
			end else if (msd_q && !side_q) begin
				c1 = c1 - CNT_W'(1);
				c0 = c0 + CNT_W'(1);
			end
		end else if (add_ok) begin
			if (side_q) begin
				c1 = c1 + CNT_W'(1);
			end else begin
				c0 = c0 + CNT_W'(1);
			end
		end
		if (add_ok && !(|pin_locked_q)) begin
			crit_add = (c0 < CNT_W'(2)) || (c1 < CNT_W'(2));
		end else begin
			crit_add = crit_q;
		end
	end

	// Move: counts relative to the side the node leaves.
	always_comb begin
		fu = msd_q ? u1_q : u0_q;
		fl = msd_q ? l1_q : l0_q;
		tu = msd_q ? u0_q : u1_q;
		tl = msd_q ? l0_q : l1_q;
		g1 = crit_q && (tl == '0) && ((tu == '0) || (tu == CNT_W'(1)));
		g2 = crit_q && (fl == '0) && ((fu == CNT_W'(1)) || (fu == CNT_W'(2)));
		if (frozen_q) begin
			crit_mv = 1'b0;
			frz_mv  = 1'b1;
		end else if (fl != '0) begin
			crit_mv = 1'b0;
			frz_mv  = 1'b1;
		end else begin
			crit_mv = (fu != '0) && (fu <= CNT_W'(3));
			frz_mv  = 1'b0;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = m_q;
		wr_data = '{side: side_q, node: node_q};
		if (state_q == S_EVAL) begin
			if (op_q == OP_ADD) begin
				wr_en   = add_ok;
				wr_addr = found_q ? m_q : count_q[IDX_W-1:0];
			end else begin
				wr_en        = found_q;
				wr_data.side = !msd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pin_mem[wr_addr] <= wr_data;
		end
		rd_s1 <= pin_mem[raddr];
	end

	// The output register stays full until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			pin_locked_q <= '0;
			crit_q       <= 1'b1;
			frozen_q     <= 1'b0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			pend_soft_q  <= 1'b0;
			n_q          <= '0;
			grp_q        <= 1'b0;
		end else begin
			idx_q <= raddr;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q        <= req.operation;
						node_q      <= req.node_id[NODE_W-1:0];
						side_q      <= req.side;
						found_q     <= 1'b0;
						u0_q        <= '0;
						u1_q        <= '0;
						l0_q        <= '0;
						l1_q        <= '0;
						n_q         <= '0;
						pend_soft_q <= 1'b0;
						unique case (req.operation) inside
							OP_CLEAR: begin
								count_q      <= '0;
								pin_locked_q <= '0;
								frozen_q     <= 1'b0;
								crit_q       <= 1'b1;
								pend_q       <= '{gain_node: '0, gain_change: CHG_NONE,
									net_critical: 1'b1, status: ST_OK, last: 1'b0};
								state_q      <= S_FIN;
							end
							OP_ADD, OP_MOVE: begin
								state_q <= (count_q == '0) ? S_EVAL : S_FIND;
							end
							default: begin
								pend_q  <= '{gain_node: '0, gain_change: CHG_NONE,
									net_critical: crit_q, status: ST_OK, last: 1'b0};
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_FIND: begin
					if (lk) begin
						if (rd_s1.side) l1_q <= l1_q + CNT_W'(1);
						else            l0_q <= l0_q + CNT_W'(1);
					end else begin
						if (rd_s1.side) u1_q <= u1_q + CNT_W'(1);
						else            u0_q <= u0_q + CNT_W'(1);
					end
					if (match && !found_q) begin
						found_q <= 1'b1;
						m_q     <= idx_q;
						msd_q   <= rd_s1.side;
					end
					if (last_entry) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (op_q == OP_ADD) begin
						if (!found_q && add_ok) begin
							count_q                                <= count_q + CNT_W'(1);
							pin_locked_q[count_q[IDX_W-1:0]] <= 1'b0;
						end
						crit_q  <= crit_add;
						pend_q  <= '{gain_node: '0, gain_change: CHG_NONE,
							net_critical: crit_add, status: add_ok ? ST_OK : ST_FULL,
							last: 1'b0};
						state_q <= S_FIN;
					end else if (!found_q) begin
						pend_q  <= '{gain_node: '0, gain_change: CHG_NONE,
							net_critical: crit_q, status: ST_NOT_PIN, last: 1'b0};
						state_q <= S_FIN;
					end else begin
						// The moving pin locks now; the emission scans skip it anyway.
						pin_locked_q[m_q] <= 1'b1;
						crit_q            <= crit_mv;
						frozen_q          <= frz_mv;
						pend_q            <= '{gain_node: '0, gain_change: CHG_NONE,
							net_critical: crit_mv, status: ST_OK, last: 1'b0};
						pend_soft_q       <= 1'b1;
						g2_q              <= g2;
						g1inc_q           <= (tu == '0);
						g2inc_q           <= (fu == CNT_W'(2));
						grp_q             <= !g1;
						state_q           <= (g1 || g2) ? S_EMIT : S_FIN;
					end
				end
				S_EMIT: begin
					if (emit_real && consume) begin
						if (!pend_soft_q) begin
							rsp_q <= pend_q;
						end
						pend_q      <= '{gain_node: 16'(rd_s1.node),
							gain_change: inc_sel ? CHG_INC : CHG_REDUCE,
							net_critical: crit_q, status: ST_OK, last: 1'b0};
						pend_soft_q <= 1'b0;
						n_q         <= n_q + RES_W'(1);
					end
					if (consume && last_entry) begin
						if (!grp_q && g2_q) begin
							grp_q <= 1'b1;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (slot_free) begin
						rsp_q       <= '{gain_node: pend_q.gain_node,
							gain_change: pend_q.gain_change,
							net_critical: pend_q.net_critical,
							status: pend_q.status, last: 1'b1};
						pend_soft_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PINS))
		else $error("pin count beyond table size");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIND) || (state_q == S_EMIT)) |-> (CNT_W'(idx_q) < count_q))
		else $error("table scan past the last pin");

	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && slot_free) |=> (rsp_valid_q && rsp_q.last))
		else $error("final result not marked last");

	a_none_zero_node: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.gain_change == CHG_NONE)) |-> (rsp_q.gain_node == '0))
		else $error("gain node set without a gain change");

endmodule

`default_nettype wire
